### src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// cond holds at every clock
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

### src/npps_pkg.sv
`default_nettype none

package npps_pkg;

  // table size
  localparam int MAX_CITIES = 1024;
  localparam int IDX_W      = $clog2(MAX_CITIES);
  localparam int CNT_W      = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_OK    = 2'd0,
    RES_FULL  = 2'd1,
    RES_EMPTY = 2'd2
  } res_t;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_OFFSET = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_SCAN,
    S_DRAIN,
    S_POST
  } state_t;

  localparam logic [12:0] W_RESET = 13'd640;
  localparam logic [12:0] W_MAX   = 13'd4096;
  localparam logic [11:0] H_RESET = 12'd320;
  localparam logic [11:0] H_MAX   = 12'd2048;

  localparam logic signed [19:0] LAT_LIMIT = 20'sd324000;
  localparam logic signed [20:0] LON_LIMIT = 21'sd648000;

  // 1296000 = 2^7 * 10125 and 648000 = 2^6 * 10125: shift, then divide by 10125
  // through a rounded-up reciprocal, exact for numerators below 2^26.
  localparam int X_PRE_SHIFT = 7;
  localparam int Y_PRE_SHIFT = 6;
  localparam int NUM_W       = 26;
  localparam int DIV_BASE    = 10125;
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_BASE - 1)) / 64'(DIV_BASE));
  localparam int QPROD_W     = NUM_W + RECIP_W;

  // bits of (offset + width/2) walked by the remainder unit
  localparam int MOD_W = 13;

  typedef struct packed {
    logic [20:0] lo;  // longitude + 648000
    logic [19:0] la;  // 324000 - latitude
  } city_t;

  typedef struct packed {
    logic capture;     // take the input transaction
    logic init;        // start remainder unit and scan
    logic mod_step;
    logic scan_issue;  // read one table entry into the pipeline
    logic do_op;       // apply side effects and load the result register
  } cmd_t;

  typedef struct packed {
    op_t  func;
    logic count_zero;
    logic mod_last;
    logic scan_last;
    logic pipe_empty;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### src/nearest_projected_point_search_top.sv
`default_nettype none

// Nearest projected point search. Holds a table of up to 1024 points given
// as latitude/longitude in arcseconds (clamped to +-324000 / +-648000 on
// load). func selects the transaction: 0 clears the table, 1 loads one point
// (status 1 if the table is full), 2 returns the stored point whose projection
// onto the map_width x map_height pixel map, shifted by map_offset + width/2
// with wrap-around, lies nearest to (point_x, point_y) by squared distance;
// the lowest index wins a tie, and status 2 reports an empty table. Every
// input transaction produces exactly one result transaction. Items are taken
// one at a time. A query over N stored points is paced by the scan, which reads
// one table entry per cycle through the single read port of the table memory,
// behind a remainder step for the wrap shift and a 5-stage projection pipeline.
// The result sits in an output register, so a new input is taken while it
// waits. in_stall stays high during reset. Configuration may be written only
// while the block is idle; a width of 0 acts as 1, above 4096 as 4096, and a
// height above 2048 acts as 2048.

module nearest_projected_point_search_top import npps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic signed [19:0] latitude,
  input  logic signed [20:0] longitude,
  input  logic [11:0]        point_x,
  input  logic [10:0]        point_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [9:0]         city_index,
  output logic [11:0]        where_x,
  output logic [11:0]        where_y,
  output logic [24:0]        squared_distance
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: accept, decode, remainder, scan, drain, post result
  npps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // table memory, projection pipeline, minimum tracking, result register
  npps_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .func             (func),
    .latitude         (latitude),
    .longitude        (longitude),
    .point_x          (point_x),
    .point_y          (point_y),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .status           (status),
    .city_index       (city_index),
    .where_x          (where_x),
    .where_y          (where_y),
    .squared_distance (squared_distance),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

`default_nettype wire

### src/npps_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module npps_ctrl import npps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.func == OP_QUERY && !stat.count_zero) state_next = S_MOD;
        else state_next = S_POST;
      end
      S_MOD: begin
        if (stat.mod_last) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat.pipe_empty) state_next = S_POST;
      end
      S_POST: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands per state; input held off while in reset and outside idle
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall    = rst;
        cmd.capture = in_valid && !rst;
      end
      S_DECODE: cmd.init       = 1'b1;
      S_MOD:    cmd.mod_step   = 1'b1;
      S_SCAN:   cmd.scan_issue = 1'b1;
      S_DRAIN:  ;
      S_POST:   cmd.do_op      = stat.out_free;
      default:  ;
    endcase
  end

  `ASSERT_NEXT(a_post_waits, clk, rst, state == S_POST && !stat.out_free, state == S_POST)
  `ASSERT_IMPLY(a_scan_has_rows, clk, rst, state == S_SCAN, !stat.count_zero)

endmodule

`default_nettype wire

### src/npps_datapath.sv
`default_nettype none
`include "assert_macros.svh"

module npps_datapath import npps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic [1:0]         func,
  input  logic signed [19:0] latitude,
  input  logic signed [20:0] longitude,
  input  logic [11:0]        point_x,
  input  logic [10:0]        point_y,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         status,
  output logic [9:0]         city_index,
  output logic [11:0]        where_x,
  output logic [11:0]        where_y,
  output logic [24:0]        squared_distance,
  input  cmd_t               cmd,
  output stat_t              stat
);

  // configuration
  logic [12:0] map_width;
  logic [11:0] map_height;
  logic [11:0] map_offset;
  logic [12:0] w_eff;
  logic [11:0] h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= W_RESET;
      map_height <= H_RESET;
      map_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  map_width  <= cfg_data;
        CFG_HEIGHT: map_height <= cfg_data[11:0];
        CFG_OFFSET: map_offset <= cfg_data[11:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (map_width == '0) w_eff = 13'd1;
    else if (map_width > W_MAX) w_eff = W_MAX;
    else w_eff = map_width;
    h_eff = (map_height > H_MAX) ? H_MAX : map_height;
  end

  // input capture, coordinates clamped and biased to unsigned
  op_t               func_q;
  logic [20:0]       lo_q;
  logic [19:0]       la_q;
  logic [11:0]       qx_q;
  logic [10:0]       qy_q;
  logic signed [19:0] lat_c;
  logic signed [20:0] lon_c;
  logic signed [20:0] la_full;
  logic signed [21:0] lo_full;

  always_comb begin
    if (latitude > LAT_LIMIT) lat_c = LAT_LIMIT;
    else if (latitude < -LAT_LIMIT) lat_c = -LAT_LIMIT;
    else lat_c = latitude;
    if (longitude > LON_LIMIT) lon_c = LON_LIMIT;
    else if (longitude < -LON_LIMIT) lon_c = -LON_LIMIT;
    else lon_c = longitude;
    la_full = 21'(LAT_LIMIT) - 21'(lat_c);
    lo_full = 22'(LON_LIMIT) + 22'(lon_c);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= op_t'(func);
      la_q   <= la_full[19:0];
      lo_q   <= lo_full[20:0];
      qx_q   <= point_x;
      qy_q   <= point_y;
    end
  end

  // table
  logic [CNT_W-1:0] count;
  logic             full;
  logic             load_ok;
  logic [IDX_W-1:0] scan_idx;
  city_t            mem [MAX_CITIES];
  city_t            rd_q;

  assign full    = (count == CNT_W'(MAX_CITIES));
  assign load_ok = cmd.do_op && func_q == OP_LOAD && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_op) begin
      if (func_q == OP_CLEAR) count <= '0;
      else if (load_ok) count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) mem[count[IDX_W-1:0]] <= '{lo: lo_q, la: la_q};
    if (cmd.scan_issue) rd_q <= mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.init) scan_idx <= '0;
    else if (cmd.scan_issue) scan_idx <= scan_idx + IDX_W'(1);
  end

  // (offset + width/2) mod width, one dividend bit per cycle
  logic [MOD_W-1:0] dividend;
  logic [3:0]       mod_cnt;
  logic [11:0]      mod_r;
  logic [MOD_W-1:0] mod_t;

  assign dividend = MOD_W'(map_offset) + MOD_W'(w_eff[12:1]);
  assign mod_t    = {mod_r, dividend[mod_cnt]};

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      mod_cnt <= 4'(MOD_W - 1);
      mod_r   <= '0;
    end else if (cmd.mod_step) begin
      mod_cnt <= mod_cnt - 4'd1;
      if (mod_t >= w_eff) mod_r <= 12'(mod_t - w_eff);
      else mod_r <= mod_t[11:0];
    end
  end

  // projection pipeline: rd_q -> products -> quotients -> wrap -> squares -> compare
  logic [4:0]         vld;
  logic [IDX_W-1:0]   i1, i2, i3, i4, i5;
  logic [33:0]        px_prod;
  logic [31:0]        py_prod;
  logic [QPROD_W-1:0] qxp, qyp;
  logic [12:0]        px_raw;
  logic [13:0]        px_sum, px_wrap;
  logic [11:0]        px4, py4, px5, py5;
  logic signed [13:0] dx, dy;
  logic signed [27:0] dx_sq, dy_sq;
  logic [24:0]        dx2;
  logic [22:0]        dy2;
  logic [24:0]        d5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], cmd.scan_issue};
    end
  end

  assign px_raw  = qxp[RECIP_SHIFT +: 13];
  assign px_sum  = {1'b0, px_raw} + 14'(mod_r);
  assign px_wrap = (px_sum >= 14'(w_eff)) ? px_sum - 14'(w_eff) : px_sum;
  assign dx      = $signed({2'b00, px4}) - $signed({2'b00, qx_q});
  assign dy      = $signed({2'b00, py4}) - $signed({3'b000, qy_q});
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  assign d5      = dx2 + 25'(dy2);

  always_ff @(posedge clk) begin
    i1      <= scan_idx;
    i2      <= i1;
    i3      <= i2;
    i4      <= i3;
    i5      <= i4;
    px_prod <= 34'(w_eff) * 34'(rd_q.lo);
    py_prod <= 32'(h_eff) * 32'(rd_q.la);
    qxp     <= QPROD_W'(px_prod[X_PRE_SHIFT +: NUM_W]) * QPROD_W'(RECIP);
    qyp     <= QPROD_W'(py_prod[Y_PRE_SHIFT +: NUM_W]) * QPROD_W'(RECIP);
    px4     <= px_wrap[11:0];
    py4     <= qyp[RECIP_SHIFT +: 12];
    px5     <= px4;
    py5     <= py4;
    dx2     <= dx_sq[24:0];
    dy2     <= dy_sq[22:0];
  end

  // running minimum, first index kept on a tie
  logic             found;
  logic [24:0]      best_d;
  logic [11:0]      best_x, best_y;
  logic [IDX_W-1:0] best_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.init) begin
      found <= 1'b0;
    end else if (vld[4]) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vld[4] && (!found || d5 < best_d)) begin
      best_d <= d5;
      best_x <= px5;
      best_y <= py5;
      best_i <= i5;
    end
  end

  // result register
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.do_op) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_op) begin
      status           <= RES_OK;
      city_index       <= '0;
      where_x          <= '0;
      where_y          <= '0;
      squared_distance <= '0;
      case (func_q)
        OP_CLEAR: ;
        OP_LOAD: begin
          if (full) status <= RES_FULL;
          else city_index <= 10'(count[IDX_W-1:0]);
        end
        OP_QUERY: begin
          if (count == '0) begin
            status <= RES_EMPTY;
          end else begin
            city_index       <= 10'(best_i);
            where_x          <= best_x;
            where_y          <= best_y;
            squared_distance <= best_d;
          end
        end
        OP_NOP:  ;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.func       = func_q;
    stat.count_zero = (count == '0);
    stat.mod_last   = (mod_cnt == '0);
    stat.scan_last  = ({1'b0, scan_idx} == count - CNT_W'(1));
    stat.pipe_empty = (vld == '0);
    stat.out_free   = out_free;
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(MAX_CITIES))
  `ASSERT_IMPLY(a_scan_in_table, clk, rst, cmd.scan_issue, {1'b0, scan_idx} < count)
  `ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.do_op, !out_valid || !out_stall)
  `ASSERT_NEXT(a_found_after_row, clk, rst, vld[4] && !cmd.init, found)

endmodule

`default_nettype wire

### dv/nearest_point_checker.sv
`timescale 1ns / 100ps

// Watches the config port and both channels, keeps its own copy of the point
// table and the map registers, and checks every result transaction in order.
module nearest_point_checker import npps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         func,
  input  logic signed [19:0] latitude,
  input  logic signed [20:0] longitude,
  input  logic [11:0]        point_x,
  input  logic [10:0]        point_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  input  logic [9:0]         city_index,
  input  logic [11:0]        where_x,
  input  logic [11:0]        where_y,
  input  logic [24:0]        squared_distance,
  output int                 fail_count,
  output int                 pending
);

  localparam int LAT_SPAN = LAT_LIMIT;
  localparam int LON_SPAN = LON_LIMIT;

  typedef struct packed {
    res_t        st;
    logic [9:0]  idx;
    logic [11:0] x;
    logic [11:0] y;
    logic [24:0] d;
  } outcome_t;

  int          stored_lat [MAX_CITIES];
  int          stored_lon [MAX_CITIES];
  int          city_total;
  logic [12:0] map_w;
  logic [11:0] map_h;
  logic [11:0] map_off;
  outcome_t    expected_outcomes [$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic int clamp(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // applies one transaction to the shadow table and returns its outcome
  function automatic outcome_t nearest_outcome(op_t f, logic signed [19:0] lat_in,
                                               logic signed [20:0] lon_in,
                                               logic [11:0] qx, logic [10:0] qy);
    outcome_t r;
    longint   w, h, lo, la, px, py, dx, dy, d, best_d;
    r = '0;
    case (f)
      OP_CLEAR: city_total = 0;
      OP_LOAD: begin
        if (city_total >= MAX_CITIES) begin
          r.st = RES_FULL;
        end else begin
          stored_lat[city_total] = clamp(int'(lat_in), LAT_SPAN);
          stored_lon[city_total] = clamp(int'(lon_in), LON_SPAN);
          r.idx = city_total[9:0];
          city_total++;
        end
      end
      OP_QUERY: begin
        if (city_total == 0) begin
          r.st = RES_EMPTY;
        end else begin
          w = map_w;
          if (w == 0) w = 1;
          else if (w > 4096) w = 4096;
          h = (map_h > 2048) ? 2048 : map_h;
          best_d = -1;
          for (int i = 0; i < city_total; i++) begin
            lo = longint'(stored_lon[i]) + LON_SPAN;
            la = LAT_SPAN - longint'(stored_lat[i]);
            px = (w * lo) / 1296000;
            py = (h * la) / 648000;
            px = (px + longint'(map_off) + w / 2) % w;
            dx = px - longint'(qx);
            dy = py - longint'(qy);
            d = dx * dx + dy * dy;
            // strict compare keeps the lowest index on a tie
            if (best_d < 0 || d < best_d) begin
              best_d = d;
              r.idx = i[9:0];
              r.x = px[11:0];
              r.y = py[11:0];
              r.d = best_d[24:0];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int field_differs(string what, longint want, longint got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      city_total = 0;
      map_w = W_RESET;
      map_h = H_RESET;
      map_off = '0;
      expected_outcomes.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  map_w = cfg_data;
          CFG_HEIGHT: map_h = cfg_data[11:0];
          CFG_OFFSET: map_off = cfg_data[11:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          if (field_differs("status", want.st, status) +
              field_differs("city_index", want.idx, city_index) +
              field_differs("where_x", want.x, where_x) +
              field_differs("where_y", want.y, where_y) +
              field_differs("squared_distance", want.d, squared_distance) != 0)
            mismatches++;
        end
      end
      if (in_valid && !in_stall)
        expected_outcomes.push_back(nearest_outcome(op_t'(func), latitude, longitude,
                                                    point_x, point_y));
      pending <= expected_outcomes.size();
    end
  end

endmodule

### dv/nearest_projected_point_search_top_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict. Checking lives in nearest_point_checker.
module nearest_projected_point_search_top_tb;
  import npps_pkg::*;

  // minimum number of non-nop transactions in the random part
  localparam int RANDOM_ITEMS = 580;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [12:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = '0;
  logic signed [19:0] latitude = '0;
  logic signed [20:0] longitude = '0;
  logic [11:0]        point_x = '0;
  logic [10:0]        point_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [9:0]         city_index;
  logic [11:0]        where_x;
  logic [11:0]        where_y;
  logic [24:0]        squared_distance;
  int                 fail_count;
  int                 pending;

  // stimulus bookkeeping
  bit tx_quiet = 1'b0;   // sender never idles while set
  bit rx_quiet = 1'b0;   // receiver never stalls while set
  int sent_items = 0;    // accepted transactions, nops excluded
  int loaded = 0;        // points loaded since the last clear
  int cur_w = 640;       // effective map size, used to aim queries
  int cur_h = 320;
  int last_lat = 0;      // last loaded point, reused to force ties
  int last_lon = 0;
  int stall_left = 0;

  always #2 clk = ~clk;

  nearest_projected_point_search_top dut (.*);
  nearest_point_checker checker_i (.*);

  // Receiver: after each accepted result draw a random stall, counted down in stall_left.
  // Stall is also held while no result is waiting, so it hits every phase.
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      n = rx_quiet ? 0 : $urandom_range(0, 7);
      stall_left <= n;
      out_stall <= (n != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end
  end

  // One transaction. Called at a rising edge, returns at the edge that took it;
  // valid stays high so a back-to-back item needs only one assignment.
  task automatic send(input op_t f, input int lat, input int lon,
                      input int qx, input int qy);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    latitude  <= lat[19:0];
    longitude <= lon[20:0];
    point_x   <= qx[11:0];
    point_y   <= qy[10:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f != OP_NOP) sent_items++;
  endtask

  // mostly in-range points, some raw bit patterns that may need to saturate,
  // and now and then a repeat of the previous point to make ties
  task automatic load_point();
    int lat, lon, r;
    r = $urandom_range(0, 19);
    if (r < 2) begin
      lat = last_lat;
      lon = last_lon;
    end else if (r < 5) begin
      lat = $urandom;
      lon = $urandom;
      lat = int'($signed(lat[19:0]));
      lon = int'($signed(lon[20:0]));
    end else begin
      lat = int'($urandom_range(0, 648000)) - 324000;
      lon = int'($urandom_range(0, 1296000)) - 648000;
    end
    last_lat = lat;
    last_lon = lon;
    send(OP_LOAD, lat, lon, $urandom_range(0, 4095), $urandom_range(0, 2047));
    loaded++;
  endtask

  // half the queries are aimed at the map, half anywhere in the field range
  task automatic query_point();
    if ($urandom_range(0, 1) != 0)
      send(OP_QUERY, $urandom, $urandom, $urandom_range(0, cur_w - 1),
           $urandom_range(0, (cur_h > 2047) ? 2047 : cur_h));
    else
      send(OP_QUERY, $urandom, $urandom, $urandom_range(0, 4095),
           $urandom_range(0, 2047));
  endtask

  task automatic clear_table();
    send(OP_CLEAR, $urandom, $urandom, $urandom_range(0, 4095), $urandom_range(0, 2047));
    loaded = 0;
  endtask

  // Stop sending and wait until every result has come back. Each input gives
  // exactly one result, so the block is idle then; a few spare cycles anyway.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // all three map registers, back to back; only while idle
  task automatic program_map(input int w, input int h, input int off);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w[12:0];
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= {1'b0, h[11:0]};
    @(posedge clk);
    cfg_index <= CFG_OFFSET;
    cfg_data  <= {1'b0, off[11:0]};
    @(posedge clk);
    cfg_we <= 1'b0;
    w = w[12:0];
    h = h[11:0];
    cur_w = (w == 0) ? 1 : (w > 4096) ? 4096 : w;
    cur_h = (h > 2048) ? 2048 : h;
  endtask

  // settings 0..7 cover the extremes: zero and oversize width/height,
  // offset at and above the width, and random sizes
  task automatic pick_map(input int sel);
    int w;
    case (sel)
      0: program_map(640, 320, 0);
      1: program_map(0, 0, 0);
      2: program_map(4096, 2048, 4095);
      3: program_map(8191, 4095, $urandom_range(0, 4095));
      4: program_map(1, 1, 0);
      5: begin
        w = $urandom_range(1, 4096);
        program_map(w, $urandom_range(1, 2048), $urandom_range(0, w - 1));
      end
      6: program_map($urandom_range(2, 300), $urandom_range(1, 2048),
                     $urandom_range(0, 4095));
      default: program_map(4097, 2049, 4095);
    endcase
  endtask

  initial begin
    int phase, n, r, target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset map settings (640 x 320, no offset)
    send(OP_QUERY, 0, 0, 0, 0);                    // empty table
    send(OP_NOP, -1, -1, 4095, 2047);
    send(OP_LOAD, 324000, 648000, 0, 0);           // corner extremes
    send(OP_LOAD, -324000, -648000, 4095, 2047);
    send(OP_LOAD, 0, 0, 0, 0);
    send(OP_LOAD, 524287, 1048575, 0, 0);          // saturate high
    send(OP_LOAD, -524288, -1048576, 0, 0);        // saturate low
    send(OP_LOAD, 0, 0, 0, 0);                     // tie with entry 2
    send(OP_QUERY, 0, 0, 0, 0);
    send(OP_QUERY, 0, 0, 4095, 2047);
    send(OP_QUERY, 0, 0, 0, 160);                  // exact hit on the tied pair
    send(OP_QUERY, 0, 0, 639, 319);
    send(OP_QUERY, -1, -1, 320, 160);
    send(OP_NOP, 0, 0, 0, 0);
    clear_table();
    send(OP_QUERY, 0, 0, 100, 100);                // empty again after clear
    loaded = 0;
    load_point();
    query_point();
    wait_for_results();

    // random part: per phase a map setting, an optional clear, a burst of
    // loads and then queries mixed with noise; every phase ends drained
    target = sent_items + RANDOM_ITEMS;
    phase = 0;
    while (sent_items < target) begin
      pick_map((phase < 8) ? phase : $urandom_range(0, 7));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (loaded > 150 || $urandom_range(0, 4) != 0) clear_table();
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 24);
      repeat (n) load_point();
      n = $urandom_range(3, 12);
      repeat (n) begin
        r = $urandom_range(0, 11);
        if (r == 0) begin
          send(OP_NOP, $urandom, $urandom, $urandom_range(0, 4095), $urandom_range(0, 2047));
        end else if (r == 1) begin
          load_point();
        end else if (r == 2) begin
          clear_table();
          query_point();
          load_point();
        end else begin
          query_point();
        end
      end
      wait_for_results();
      phase++;
    end

    // fill the table to the last entry, then overfill and query it whole
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    pick_map(5);
    clear_table();
    repeat (MAX_CITIES) load_point();
    load_point();
    load_point();
    repeat (3) query_point();
    clear_table();
    query_point();
    wait_for_results();
    repeat (20) @(posedge clk);

    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
